[rtl/core/ppt_pkg.sv]
`default_nettype none
package ppt_pkg;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_BUZZ = 2'd2,
        MODE_RUN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_RANGE    = 2'd1,
        FAULT_CONFLICT = 2'd2
    } fault_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REGEN_ON   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZ_TICKS = 1'd1;
    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] BUZZ_TICKS_RESET = 16'd1500;

    // thresholds in raw sample units (1/16)
    localparam int APPS_LEFT_MAX  = -2400;
    localparam int APPS_RIGHT_MIN = 2400;
    localparam int BPPS_MIN       = 800;
    localparam int BRAKE_LOW      = -80;
    localparam int BRAKE_HIGH     = 1320;
    localparam int DEAD_LEFT_MIN  = -1200;
    localparam int DEAD_RIGHT_MAX = 1200;
    // command limits in 1/32 units
    localparam int CMD_MAX        = 48000;
    localparam int REGEN_FLOOR    = -9600;
    localparam int LATCH_SET_MIN  = 7200;
    localparam int LATCH_CLR_MAX  = 2400;
    localparam int CMD_BIAS       = 9610;   // floor offset plus half of 20

    // scaled command: (cmd + bias) / 4, always below 2**14
    localparam int SCALED_W  = 14;
    localparam int RECIP_W   = 16;
    localparam logic [RECIP_W-1:0] RECIP_DIV5 = 16'd52429;  // 2**18 / 5, rounded up
    localparam int RECIP_SH  = 18;
    localparam int QUOT_W    = 12;

    localparam int TORQUE_W  = 13;
    localparam logic signed [TORQUE_W-1:0] TORQUE_OFFSET = 13'sd480;

    typedef struct packed {
        logic                sw_released;
        logic                logging;
        logic                apps;
        logic                bpps;
        logic                range_fault;
        logic                brake_sum_hi;
        logic                cmd_hi;
        logic                cmd_lo;
        logic                deadband;
        logic [SCALED_W-1:0] scaled;
    } flags_t;

endpackage
`default_nettype wire

[rtl/core/pedal_plausibility_torque_fsm_top.sv]
// Path: an input beat passes the input register, then the result register.
// Throughput: one tick per cycle while m_tready is high; an empty input
//   register still takes a new beat while a result waits.
// Reset (aresetn low, synchronous): mode stopped, buzz counter, latch,
//   lamp and buzzer cleared, both stages empty, regen off, buzz_ticks 1500.
`default_nettype none
module pedal_plausibility_torque_fsm_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // accel_left, accel_right, brake_left, brake_right, ready_switch,
    // logging_active, zero fill
    input  wire logic [((4*SAMPLE_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // torque_cmd[12:0], mode[14:13], ready_lamp[15], buzzer[16],
    // fault[18:17], zero fill
    output logic [23:0]                              m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ppt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SB = SAMPLE_BITS;

    logic        regen_on_reg;
    logic [15:0] buzz_ticks_reg;

    logic            flags_valid, flags_take;
    ppt_pkg::flags_t flags;

    logic signed [ppt_pkg::TORQUE_W-1:0] torque_cmd;
    logic [1:0]                          mode;
    logic                                ready_lamp;
    logic                                buzzer;
    logic [1:0]                          fault;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regen_on_reg   <= 1'b0;
            buzz_ticks_reg <= ppt_pkg::BUZZ_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ppt_pkg::REG_REGEN_ON:   regen_on_reg   <= cfg_data[0];
                ppt_pkg::REG_BUZZ_TICKS: buzz_ticks_reg <= cfg_data[15:0];
                default: begin
                    regen_on_reg <= regen_on_reg;
                end
            endcase
        end
    end

    ppt_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .accel_left     (s_tdata[0*SB +: SB]),
        .accel_right    (s_tdata[1*SB +: SB]),
        .brake_left     (s_tdata[2*SB +: SB]),
        .brake_right    (s_tdata[3*SB +: SB]),
        .ready_switch   (s_tdata[4*SB]),
        .logging_active (s_tdata[4*SB+1]),
        .regen_on       (regen_on_reg),
        .flags_valid    (flags_valid),
        .flags_take     (flags_take),
        .flags          (flags)
    );

    ppt_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .flags_valid (flags_valid),
        .flags_take  (flags_take),
        .flags       (flags),
        .buzz_ticks  (buzz_ticks_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .torque_cmd  (torque_cmd),
        .mode        (mode),
        .ready_lamp  (ready_lamp),
        .buzzer      (buzzer),
        .fault       (fault)
    );

    assign m_tdata = {5'd0, fault, buzzer, ready_lamp, mode, torque_cmd};

endmodule
`default_nettype wire

[rtl/core/ppt_front.sv]
`default_nettype none
module ppt_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_left,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_right,
    input  wire logic signed [SAMPLE_BITS-1:0] brake_left,
    input  wire logic signed [SAMPLE_BITS-1:0] brake_right,
    input  wire logic                          ready_switch,
    input  wire logic                          logging_active,
    input  wire logic                          regen_on,
    output logic                               flags_valid,
    input  wire logic                          flags_take,
    output ppt_pkg::flags_t                    flags
);

    localparam int W = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;

    localparam logic signed [W-1:0] APPS_L   = W'(ppt_pkg::APPS_LEFT_MAX);
    localparam logic signed [W-1:0] APPS_R   = W'(ppt_pkg::APPS_RIGHT_MIN);
    localparam logic signed [W-1:0] BPPS     = W'(ppt_pkg::BPPS_MIN);
    localparam logic signed [W-1:0] BRK_LO   = W'(ppt_pkg::BRAKE_LOW);
    localparam logic signed [W-1:0] BRK_HI   = W'(ppt_pkg::BRAKE_HIGH);
    localparam logic signed [W-1:0] DEAD_L   = W'(ppt_pkg::DEAD_LEFT_MIN);
    localparam logic signed [W-1:0] DEAD_R   = W'(ppt_pkg::DEAD_RIGHT_MAX);
    localparam logic signed [W-1:0] CMD_TOP  = W'(ppt_pkg::CMD_MAX);
    localparam logic signed [W-1:0] FLOOR_RG = W'(ppt_pkg::REGEN_FLOOR);
    localparam logic signed [W-1:0] SET_MIN  = W'(ppt_pkg::LATCH_SET_MIN);
    localparam logic signed [W-1:0] CLR_MAX  = W'(ppt_pkg::LATCH_CLR_MAX);
    localparam logic signed [W-1:0] BIAS     = W'(ppt_pkg::CMD_BIAS);

    logic signed [W-1:0] al, ar, bl, br;
    logic signed [W-1:0] floor_val, cmd_raw, cmd_clamp, cmd_biased;
    ppt_pkg::flags_t     flags_new;
    logic                valid_reg, valid_next;
    ppt_pkg::flags_t     flags_reg;

    assign al = W'(accel_left);
    assign ar = W'(accel_right);
    assign bl = W'(brake_left);
    assign br = W'(brake_right);

    always_comb begin
        floor_val = regen_on ? FLOOR_RG : '0;
        cmd_raw   = ar - al + floor_val;
        if (cmd_raw > CMD_TOP) begin
            cmd_clamp = CMD_TOP;
        end else if (cmd_raw < floor_val) begin
            cmd_clamp = floor_val;
        end else begin
            cmd_clamp = cmd_raw;
        end
        cmd_biased = cmd_clamp + BIAS;

        flags_new.sw_released  = ready_switch;
        flags_new.logging      = logging_active;
        flags_new.apps         = (al < APPS_L) && (ar > APPS_R);
        flags_new.bpps         = (bl > BPPS) && (br > BPPS);
        flags_new.range_fault  = (bl < BRK_LO) || (br < BRK_LO) ||
                                 (bl > BRK_HI) || (br > BRK_HI);
        flags_new.brake_sum_hi = (bl + br) > BPPS;
        flags_new.cmd_hi       = cmd_clamp >= SET_MIN;
        flags_new.cmd_lo       = cmd_clamp <= CLR_MAX;
        flags_new.deadband     = (al >= DEAD_L) && (ar <= DEAD_R);
        // divide by four here, the divide by five follows in the core
        flags_new.scaled       = cmd_biased[ppt_pkg::SCALED_W+1:2];
    end

    assign in_ready = !valid_reg || flags_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (flags_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            flags_reg <= flags_new;
        end
    end

    assign flags_valid = valid_reg;
    assign flags       = flags_reg;

endmodule
`default_nettype wire

[rtl/core/ppt_core.sv]
`default_nettype none
module ppt_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             flags_valid,
    output logic                                  flags_take,
    input  wire ppt_pkg::flags_t                  flags,
    input  wire logic [15:0]                      buzz_ticks,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [ppt_pkg::TORQUE_W-1:0]   torque_cmd,
    output logic [1:0]                            mode,
    output logic                                  ready_lamp,
    output logic                                  buzzer,
    output logic [1:0]                            fault
);

    localparam int PROD_W = ppt_pkg::SCALED_W + ppt_pkg::RECIP_W;

    ppt_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    buzz_count_reg, buzz_count_next, buzz_inc;
    logic           latch_reg, latch_next;
    logic           lamp_reg, lamp_next;
    logic           buzzer_reg, buzzer_next;
    logic           out_valid_reg, out_valid_next;

    logic signed [ppt_pkg::TORQUE_W-1:0] torque_reg, torque_next;
    ppt_pkg::fault_t                     fault_reg, fault_next;

    logic [PROD_W-1:0]                   prod;
    logic [ppt_pkg::QUOT_W-1:0]          quot;
    logic                                zero;

    assign flags_take = flags_valid && (!out_valid_reg || out_ready);
    assign buzz_inc   = buzz_count_reg + 16'd1;

    // mode transitions
    always_comb begin
        mode_next = mode_reg;
        if (flags_take) begin
            case (mode_reg)
                ppt_pkg::MODE_STOP: begin
                    if (!flags.sw_released) begin
                        if (flags.apps && !flags.bpps) begin
                            mode_next = ppt_pkg::MODE_CAL;
                        end else if (!flags.apps && flags.bpps) begin
                            mode_next = ppt_pkg::MODE_BUZZ;
                        end
                    end
                end
                ppt_pkg::MODE_CAL: begin
                    if (flags.sw_released) begin
                        mode_next = ppt_pkg::MODE_STOP;
                    end
                end
                ppt_pkg::MODE_BUZZ: begin
                    if (buzz_inc >= buzz_ticks) begin
                        mode_next = ppt_pkg::MODE_RUN;
                    end
                end
                ppt_pkg::MODE_RUN: begin
                    mode_next = ppt_pkg::MODE_RUN;
                end
                default: begin
                    mode_next = ppt_pkg::MODE_STOP;
                end
            endcase
        end
    end

    // torque scaling: quotient of scaled by five through the reciprocal
    assign prod = PROD_W'(flags.scaled) * PROD_W'(ppt_pkg::RECIP_DIV5);
    assign quot = prod[ppt_pkg::RECIP_SH +: ppt_pkg::QUOT_W];

    // per-mode outputs and side state
    always_comb begin
        buzz_count_next = buzz_count_reg;
        latch_next      = latch_reg;
        lamp_next       = lamp_reg;
        buzzer_next     = buzzer_reg;
        fault_next      = ppt_pkg::FAULT_NONE;
        zero            = 1'b1;
        case (mode_reg)
            ppt_pkg::MODE_STOP: begin
                lamp_next = 1'b0;
                if (!flags.sw_released && !flags.apps && flags.bpps) begin
                    buzz_count_next = '0;
                end
            end
            ppt_pkg::MODE_CAL: begin
                lamp_next = lamp_reg;
            end
            ppt_pkg::MODE_BUZZ: begin
                lamp_next       = 1'b1;
                buzzer_next     = !buzzer_reg;
                buzz_count_next = buzz_inc;
            end
            ppt_pkg::MODE_RUN: begin
                zero = 1'b0;
                if (!flags.logging) begin
                    if (flags.range_fault) begin
                        zero       = 1'b1;
                        fault_next = ppt_pkg::FAULT_RANGE;
                    end else if (!latch_reg && flags.brake_sum_hi && flags.cmd_hi) begin
                        latch_next = 1'b1;
                        zero       = 1'b1;
                        fault_next = ppt_pkg::FAULT_CONFLICT;
                    end else if (latch_reg && !flags.cmd_lo) begin
                        zero       = 1'b1;
                        fault_next = ppt_pkg::FAULT_CONFLICT;
                    end else if (latch_reg) begin
                        latch_next = 1'b0;
                    end
                end
                if (flags.deadband) begin
                    zero = 1'b1;
                end
            end
            default: begin
                zero = 1'b1;
            end
        endcase
        torque_next = zero ? '0
                           : signed'(ppt_pkg::TORQUE_W'(quot)) - ppt_pkg::TORQUE_OFFSET;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (flags_take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ppt_pkg::MODE_STOP;
            buzz_count_reg <= '0;
            latch_reg      <= 1'b0;
            lamp_reg       <= 1'b0;
            buzzer_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            if (flags_take) begin
                buzz_count_reg <= buzz_count_next;
                latch_reg      <= latch_next;
                lamp_reg       <= lamp_next;
                buzzer_reg     <= buzzer_next;
            end
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (flags_take) begin
            torque_reg <= torque_next;
            fault_reg  <= fault_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign torque_cmd = torque_reg;
    assign mode       = mode_reg;
    assign ready_lamp = lamp_reg;
    assign buzzer     = buzzer_reg;
    assign fault      = fault_reg;

endmodule
`default_nettype wire

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 250000;

    typedef struct {
        logic signed [15:0] accel_l;
        logic signed [15:0] accel_r;
        logic signed [15:0] brake_l;
        logic signed [15:0] brake_r;
        logic               sw_released;
        logic               logging;
    } tick_t;

    // Tracks the mode machine, latch and lamp/buzzer pins tick by tick and
    // queues the command beat each accepted tick must produce.
    class torque_cmd_tracker;
        ppt_pkg::mode_t ctl_mode;
        logic [15:0]    buzz_cnt;
        logic [15:0]    buzz_limit;
        bit             conflict;
        bit             lamp;
        bit             buzz_pin;
        bit             regen;
        logic [18:0]    cmd_beats[$];
        int             errors;
        int             ticks;
        int             checked;

        function new();
            ctl_mode   = ppt_pkg::MODE_STOP;
            buzz_cnt   = '0;
            buzz_limit = 16'd1500;
            conflict   = 1'b0;
            lamp       = 1'b0;
            buzz_pin   = 1'b0;
            regen      = 1'b0;
            errors     = 0;
            ticks      = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [ppt_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == ppt_pkg::REG_REGEN_ON)
                regen = val[0];
            else if (idx == ppt_pkg::REG_BUZZ_TICKS)
                buzz_limit = val;
        endfunction

        function void step_tick(tick_t t);
            int              al, ar, bl, br, flr, cmd, tq;
            bit              apps, bpps, zero;
            ppt_pkg::fault_t flt;
            al   = t.accel_l;
            ar   = t.accel_r;
            bl   = t.brake_l;
            br   = t.brake_r;
            tq   = 0;
            zero = 1'b0;
            flt  = ppt_pkg::FAULT_NONE;
            ticks++;
            case (ctl_mode)
                ppt_pkg::MODE_STOP: begin
                    apps = al < -2400 && ar > 2400;
                    bpps = bl > 800 && br > 800;
                    lamp = 1'b0;
                    if (!t.sw_released) begin
                        if (apps && !bpps) begin
                            ctl_mode = ppt_pkg::MODE_CAL;
                        end else if (!apps && bpps) begin
                            ctl_mode = ppt_pkg::MODE_BUZZ;
                            buzz_cnt = '0;
                        end
                    end
                end
                ppt_pkg::MODE_CAL: begin
                    if (t.sw_released)
                        ctl_mode = ppt_pkg::MODE_STOP;
                end
                ppt_pkg::MODE_BUZZ: begin
                    lamp     = 1'b1;
                    buzz_pin = ~buzz_pin;
                    buzz_cnt = buzz_cnt + 16'd1;
                    if (buzz_cnt >= buzz_limit)
                        ctl_mode = ppt_pkg::MODE_RUN;
                end
                default: begin
                    // command in 1/32 units, offset by the regen floor
                    flr = regen ? -9600 : 0;
                    cmd = ar - al + flr;
                    if (cmd > 48000)
                        cmd = 48000;
                    if (cmd < flr)
                        cmd = flr;
                    if (!t.logging) begin
                        if (bl < -80 || br < -80 || bl > 1320 || br > 1320) begin
                            zero = 1'b1;
                            flt  = ppt_pkg::FAULT_RANGE;
                        end else if (!conflict && (bl + br) > 800 && cmd >= 7200) begin
                            conflict = 1'b1;
                            zero     = 1'b1;
                            flt      = ppt_pkg::FAULT_CONFLICT;
                        end else begin
                            if (conflict && cmd <= 2400)
                                conflict = 1'b0;
                            if (conflict) begin
                                zero = 1'b1;
                                flt  = ppt_pkg::FAULT_CONFLICT;
                            end
                        end
                    end
                    if (!zero && al >= -1200 && ar <= 1200)
                        zero = 1'b1;
                    // divide by 20 with halves rounded up; operand is never negative
                    if (!zero)
                        tq = (cmd + 9610) / 20 - 480;
                end
            endcase
            cmd_beats.push_back({flt, buzz_pin, lamp, ctl_mode, tq[12:0]});
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at beat %0d: %s got %0d want %0d", checked, what, got, want);
            errors++;
        endtask

        task check_beat(logic [23:0] d);
            logic [18:0] want;
            if (cmd_beats.size() == 0) begin
                report("unexpected result beat, torque_cmd", $signed(d[12:0]), 0);
                return;
            end
            want = cmd_beats.pop_front();
            checked++;
            if (d[12:0] != want[12:0])
                report("torque_cmd", $signed(d[12:0]), $signed(want[12:0]));
            if (d[14:13] != want[14:13])
                report("mode", d[14:13], want[14:13]);
            if (d[15] != want[15])
                report("ready_lamp", d[15], want[15]);
            if (d[16] != want[16])
                report("buzzer", d[16], want[16]);
            if (d[18:17] != want[18:17])
                report("fault", d[18:17], want[18:17]);
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [71:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [23:0]                    m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data;

    bit                gaps_on = 1'b1;
    int                cycles = 0;
    torque_cmd_tracker sb = new();

    pedal_plausibility_torque_fsm_top #(
        .SAMPLE_BITS(16)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check accepted beats, stall at random while gaps_on is set
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata);
            m_tready <= !gaps_on || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_tick(tick_t t);
        if (gaps_on && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 11);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, t.logging, t.sw_released, t.brake_r, t.brake_l,
                     t.accel_r, t.accel_l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.step_tick(t);
    endtask

    task automatic send_fields(int al, int ar, int bl, int br, bit sw, bit lg);
        tick_t t;
        t.accel_l     = al;
        t.accel_r     = ar;
        t.brake_l     = bl;
        t.brake_r     = br;
        t.sw_released = sw;
        t.logging     = lg;
        send_tick(t);
    endtask

    // hold the input idle until every command beat is back, then let the
    // two pipeline stages settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.cmd_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(bit regen, logic [15:0] buzz_limit);
        cfg_valid <= 1'b1;
        cfg_index <= ppt_pkg::REG_REGEN_ON;
        cfg_data  <= {15'b0, regen};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(ppt_pkg::REG_REGEN_ON, {15'b0, regen});
        cfg_index <= ppt_pkg::REG_BUZZ_TICKS;
        cfg_data  <= buzz_limit;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(ppt_pkg::REG_BUZZ_TICKS, buzz_limit);
        cfg_valid <= 1'b0;
    endtask

    function automatic tick_t any_tick();
        tick_t t;
        t.accel_l     = $urandom;
        t.accel_r     = $urandom;
        t.brake_l     = $urandom;
        t.brake_r     = $urandom;
        t.sw_released = $urandom_range(1);
        t.logging     = $urandom_range(1);
        return t;
    endfunction

    // stopped/calibrate traffic that never reaches the buzzer mode
    function automatic tick_t pre_drive_tick(ppt_pkg::mode_t now);
        tick_t t;
        int    travel, nl, nr;
        t = any_tick();
        if ($urandom_range(3) != 0) begin
            travel    = $urandom_range(0, 6000);
            nl        = $urandom_range(0, 200);
            nr        = $urandom_range(0, 200);
            t.accel_l = 100 - travel - nl;
            t.accel_r = travel + nr - 100;
            t.brake_l = $urandom_range(0, 1600);
            t.brake_r = $urandom_range(0, 1600);
        end
        if (now == ppt_pkg::MODE_STOP && !t.sw_released
            && t.brake_l > 800 && t.brake_r > 800
            && !(t.accel_l < -2400 && t.accel_r > 2400))
            t.sw_released = 1'b1;
        return t;
    endfunction

    function automatic int brake_sample(int kind);
        int v;
        case (kind)
            0: v = $urandom_range(1) ? $urandom_range(0, 4) - 82 : $urandom_range(1318, 1322);
            1: v = $urandom_range(401, 1320);
            default: v = $urandom_range(0, 480) - 80;
        endcase
        return v;
    endfunction

    function automatic tick_t drive_tick();
        tick_t t;
        int    r, travel, nl, nr;
        r = $urandom_range(99);
        t = any_tick();
        if (r < 8)
            return t;
        travel    = (r < 25) ? $urandom_range(0, 2500) : $urandom_range(0, 27000);
        nl        = $urandom_range(0, 400);
        nr        = $urandom_range(0, 400);
        t.accel_l = 200 - travel - nl;
        t.accel_r = travel + nr - 200;
        r = $urandom_range(99);
        if (r < 5) begin
            t.brake_l = $urandom;
            t.brake_r = $urandom;
        end else if (r < 12) begin
            t.brake_l = brake_sample($urandom_range(2));
            t.brake_r = brake_sample(0);
        end else if (r < 45) begin
            t.brake_l = brake_sample(1);
            t.brake_r = brake_sample(1);
        end else begin
            t.brake_l = brake_sample(2);
            t.brake_r = brake_sample(2);
        end
        t.logging = ($urandom_range(9) == 0);
        return t;
    endfunction

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        program_regs(1'b1, 16'hFFFF);

        // stopped and calibrate: trigger edges, both pedals, switch released
        send_fields(-32768, 32767, 32767, 32767, 1'b0, 1'b1);
        send_fields(32767, -32768, -32768, -32768, 1'b0, 1'b0);
        send_fields(-2400, 2401, 0, 0, 1'b0, 1'b0);
        send_fields(-2401, 2400, 0, 0, 1'b0, 1'b0);
        send_fields(-2401, 2401, 801, 800, 1'b1, 1'b0);
        send_fields(-2401, 2401, 801, 800, 1'b0, 1'b0);
        send_fields(0, 0, 801, 801, 1'b0, 1'b1);
        send_fields(0, 0, 0, 0, 1'b1, 1'b0);

        repeat (100) send_tick(pre_drive_tick(sb.ctl_mode));
        if (sb.ctl_mode == ppt_pkg::MODE_CAL)
            send_fields(0, 0, 0, 0, 1'b1, 1'b0);

        // brake and switch only: enter the buzzer mode
        send_fields(0, 0, 801, 801, 1'b0, 1'b0);
        repeat (15) send_tick(any_tick());
        drain();
        // a limit below the count already reached ends buzzing on the next tick
        program_regs(1'b1, 16'd0);
        send_tick(any_tick());

        // running, regen on: clamps, range fault, conflict latch, deadband
        send_fields(-32768, 32767, 0, 0, 1'b0, 1'b0);
        send_fields(-1201, -32768, 0, 0, 1'b1, 1'b0);
        send_fields(32767, -32768, 0, 0, 1'b0, 1'b0);
        send_fields(-8400, 8400, -81, 0, 1'b0, 1'b0);
        send_fields(-8400, 8400, 0, 1321, 1'b0, 1'b0);
        send_fields(-8400, 8400, -80, 1320, 1'b0, 1'b0);
        send_fields(-32768, 32767, -32768, 0, 1'b1, 1'b0);
        send_fields(-20000, 20000, 0, 0, 1'b0, 1'b1);
        send_fields(-6001, 6000, 0, 0, 1'b0, 1'b0);
        send_fields(-6000, 6000, 0, 0, 1'b0, 1'b0);
        send_fields(-8400, 8400, 400, 400, 1'b0, 1'b0);
        send_fields(-8400, 8399, 401, 400, 1'b0, 1'b0);
        send_fields(-4805, 4805, 0, 0, 1'b0, 1'b0);
        send_fields(-1200, 1200, 0, 0, 1'b0, 1'b0);
        send_fields(-1201, 1200, 0, 0, 1'b0, 1'b0);
        send_fields(0, 0, 32767, 32767, 1'b0, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            program_regs(phase[0], (phase == 0) ? 16'd1 : 16'($urandom));
            gaps_on = (phase != 3);
            repeat (70) send_tick(drive_tick());
        end
        gaps_on = 1'b1;
        drain();

        $display("%0d ticks through stopped, calibrate, buzzer and running modes", sb.ticks);
        $display("%0d command beats checked with regen on and off", sb.checked);
        if (sb.errors == 0 && sb.cmd_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/core/ppt_pkg.sv
rtl/core/ppt_front.sv
rtl/core/ppt_core.sv
rtl/core/pedal_plausibility_torque_fsm_top.sv
tb/tb.sv
